// File: sv/lcpe_pkg.sv
package lcpe_pkg;

    localparam int unsigned COLOR_W   = 8;
    localparam int unsigned WORD_W    = 24;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned PROD_W    = COLOR_W + PCT_W;
    localparam int unsigned TICK_W    = 15;
    localparam int unsigned IDX_W     = 5;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // x/100 == (x*5243)>>19 for every x below 43690
    localparam int unsigned RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned RPROD_W     = PROD_W + RECIP_W;

    localparam logic [TICK_W-1:0] RESET_LOW_TICKS  = TICK_W'(16320);
    localparam logic [TICK_W-1:0] HEAD_TAIL_TICKS  = TICK_W'(300);
    localparam logic [TICK_W-1:0] TRAIL_TAIL_TICKS = TICK_W'(100);
    localparam logic [TICK_W-1:0] ZERO_HIGH_TICKS  = TICK_W'(23);
    localparam logic [TICK_W-1:0] ZERO_LOW_TICKS   = TICK_W'(73);
    localparam logic [TICK_W-1:0] ONE_HIGH_TICKS   = TICK_W'(72);
    localparam logic [TICK_W-1:0] ONE_LOW_TICKS    = TICK_W'(24);

    localparam logic [IDX_W-1:0] WORD_TOP_IDX = IDX_W'(WORD_W - 1);
    localparam logic [IDX_W-1:0] GAIN_TOP_IDX = IDX_W'(GAIN_W - 1);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_POWER      = 2'd1;
    localparam logic [1:0] REG_GAIN       = 2'd2;

    typedef struct packed {
        logic              has_reset;
        logic              has_bits;
        logic              has_tail;
        logic              overflow;
        logic [WORD_W-1:0] word;
        logic [GAIN_W-1:0] gain;
    } cmd_t;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_ticks;
        logic              second_level;
        logic [TICK_W-1:0] second_ticks;
        logic              last_of_run;
        logic              frame_overflow;
    } pulse_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_BITS,
        PH_GAIN,
        PH_TRAIL
    } phase_t;

endpackage

// File: sv/led_chain_pulse_encoder_unit.sv
// LED chain pulse encoder. Each input item carries one chip's red, green and blue bytes
// (tlast marks the last chip of a frame); each is scaled by brightness_percent/100, or
// zeroed while power_on is 0, and sent as 24 pulse items MSB first. A frame opens with a
// reset item and closes with the 16 frame_gain bits and a trailer item whose tuser flags
// chips dropped beyond MAX_CHIPS. The output gives one pulse item per cycle while m_tready
// is high; the pulse sequencer is the limit. Input items pass a two-stage scaling pipeline
// and a four-entry command queue, so several chips are taken ahead of the output; on an
// idle block the first pulse item of an item passes stage 1, stage 2, the queue and the
// output register. Register map: 0x0 brightness_percent, 0x4 power_on, 0x8 frame_gain.
module led_chain_pulse_encoder_unit
    import lcpe_pkg::*;
#(
    parameter int unsigned MAX_CHIPS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic                  s_tlast,  // last_chip
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // first_level[0], first_ticks[15:1], second_level[16], second_ticks[31:17]
    output logic [31:0]           m_tdata,
    output logic                  m_tlast,  // last_of_run
    output logic                  m_tuser,  // frame_overflow
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [PCT_W-1:0]  brightness_reg;
    logic              power_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              cfg_wr;

    logic   q_in_valid;
    logic   q_in_ready;
    cmd_t   q_in_data;
    logic   q_out_valid;
    logic   q_out_ready;
    cmd_t   q_out_data;
    pulse_t item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= PCT_FULL;
            power_reg      <= 1'b1;
            gain_reg       <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BRIGHTNESS: brightness_reg <= pwdata[PCT_W-1:0];
                REG_POWER:      power_reg      <= pwdata[0];
                REG_GAIN:       gain_reg       <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BRIGHTNESS: prdata = 32'(brightness_reg);
            REG_POWER:      prdata = 32'(power_reg);
            REG_GAIN:       prdata = 32'(gain_reg);
            default:        prdata = '0;
        endcase
    end

    lcpe_front #(
        .MAX_CHIPS(MAX_CHIPS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .red_in            (s_tdata[7:0]),
        .green_in          (s_tdata[15:8]),
        .blue_in           (s_tdata[23:16]),
        .last_chip         (s_tlast),
        .brightness_percent(brightness_reg),
        .power_on          (power_reg),
        .frame_gain        (gain_reg),
        .cmd_valid         (q_in_valid),
        .cmd_ready         (q_in_ready),
        .cmd_data          (q_in_data)
    );

    lcpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(q_in_valid),
        .push_ready(q_in_ready),
        .push_data (q_in_data),
        .pop_valid (q_out_valid),
        .pop_ready (q_out_ready),
        .pop_data  (q_out_data)
    );

    lcpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_out_valid),
        .cmd_ready(q_out_ready),
        .cmd_data (q_out_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (item)
    );

    assign m_tdata = {item.second_ticks, item.second_level, item.first_ticks, item.first_level};
    assign m_tlast = item.last_of_run;
    assign m_tuser = item.frame_overflow;

endmodule

// File: sv/lcpe_front.sv
module lcpe_front
    import lcpe_pkg::*;
#(
    parameter int unsigned MAX_CHIPS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COLOR_W-1:0] red_in,
    input  logic [COLOR_W-1:0] green_in,
    input  logic [COLOR_W-1:0] blue_in,
    input  logic               last_chip,
    input  logic [PCT_W-1:0]   brightness_percent,
    input  logic               power_on,
    input  logic [GAIN_W-1:0]  frame_gain,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cmd_t               cmd_data
);

    localparam int unsigned CNT_W = $clog2(MAX_CHIPS + 1);

    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] chip_cnt_reg, chip_cnt_next;
    logic             ovf_seen_reg, ovf_seen_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             s2_valid_reg, s2_valid_next;
    logic [PROD_W-1:0] s1_prod_reg [3];
    cmd_t             s1_cmd_reg;
    cmd_t             s2_cmd_reg;
    cmd_t             s2_cmd_next;

    logic             accept;
    logic             s1_free;
    logic             s2_free;
    logic [CNT_W-1:0] cnt_cur;
    logic             ovf_cur;
    logic             keep;
    logic             emit;
    logic [PCT_W-1:0] pct_eff;
    cmd_t             cmd_new;
    logic [RPROD_W-1:0] rprod [3];

    assign s2_free  = !s2_valid_reg || cmd_ready;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && in_ready;

    assign cnt_cur = in_frame_reg ? chip_cnt_reg : '0;
    assign ovf_cur = in_frame_reg && ovf_seen_reg;
    assign keep    = cnt_cur < CNT_W'(MAX_CHIPS);
    assign emit    = !in_frame_reg || keep || last_chip;

    always_comb begin
        if (!power_on) begin
            pct_eff = '0;
        end else if (brightness_percent > PCT_FULL) begin
            pct_eff = PCT_FULL;
        end else begin
            pct_eff = brightness_percent;
        end
    end

    always_comb begin
        cmd_new           = '0;
        cmd_new.has_reset = !in_frame_reg;
        cmd_new.has_bits  = keep;
        cmd_new.has_tail  = last_chip;
        cmd_new.overflow  = ovf_cur || !keep;
        cmd_new.gain      = frame_gain;
    end

    always_comb begin
        if (last_chip) begin
            in_frame_next = 1'b0;
            chip_cnt_next = '0;
            ovf_seen_next = 1'b0;
        end else begin
            in_frame_next = 1'b1;
            chip_cnt_next = cnt_cur + CNT_W'(keep);
            ovf_seen_next = ovf_cur || !keep;
        end
    end

    always_comb begin
        if (accept && emit) begin
            s1_valid_next = 1'b1;
        end else if (s2_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_valid_reg && s2_free) begin
            s2_valid_next = 1'b1;
        end else if (cmd_ready) begin
            s2_valid_next = 1'b0;
        end else begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            chip_cnt_reg <= '0;
            ovf_seen_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                in_frame_reg <= in_frame_next;
                chip_cnt_reg <= chip_cnt_next;
                ovf_seen_reg <= ovf_seen_next;
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage 1: byte * percent
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            s1_cmd_reg     <= cmd_new;
            s1_prod_reg[0] <= PROD_W'(red_in * pct_eff);
            s1_prod_reg[1] <= PROD_W'(green_in * pct_eff);
            s1_prod_reg[2] <= PROD_W'(blue_in * pct_eff);
        end
    end

    // stage 2: divide by 100 through the reciprocal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rprod[i] = RPROD_W'(s1_prod_reg[i] * RECIP_100);
        end
    end

    always_comb begin
        s2_cmd_next      = s1_cmd_reg;
        s2_cmd_next.word = {rprod[0][RECIP_SHIFT +: COLOR_W],
                            rprod[1][RECIP_SHIFT +: COLOR_W],
                            rprod[2][RECIP_SHIFT +: COLOR_W]};
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_free) begin
            s2_cmd_reg <= s2_cmd_next;
        end
    end

    assign cmd_valid = s2_valid_reg;
    assign cmd_data  = s2_cmd_reg;

endmodule

// File: sv/lcpe_queue.sv
module lcpe_queue
    import lcpe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/lcpe_back.sv
module lcpe_back
    import lcpe_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   cmd_valid,
    output logic   cmd_ready,
    input  cmd_t   cmd_data,
    output logic   out_valid,
    input  logic   out_ready,
    output pulse_t out_item
);

    phase_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    cmd_t             cmd_reg;
    logic             out_valid_reg;
    pulse_t           out_item_reg;

    logic             idle;
    logic             have;
    logic             adv;
    logic             step;
    cmd_t             cur;
    phase_t           cur_phase;
    logic [IDX_W-1:0] cur_idx;
    phase_t           after_phase;
    logic [IDX_W-1:0] after_idx;
    logic             item_last;
    pulse_t           item;
    logic             bit_val;

    assign idle      = state_reg == PH_IDLE;
    assign cur       = idle ? cmd_data : cmd_reg;
    assign have      = !idle || cmd_valid;
    assign adv       = !out_valid_reg || out_ready;
    assign step      = have && adv;
    assign cmd_ready = idle && adv;

    always_comb begin
        if (!idle) begin
            cur_phase = state_reg;
            cur_idx   = idx_reg;
        end else if (cur.has_reset) begin
            cur_phase = PH_HEAD;
            cur_idx   = WORD_TOP_IDX;
        end else if (cur.has_bits) begin
            cur_phase = PH_BITS;
            cur_idx   = WORD_TOP_IDX;
        end else begin
            cur_phase = PH_GAIN;
            cur_idx   = GAIN_TOP_IDX;
        end
    end

    // next state
    always_comb begin
        after_phase = PH_IDLE;
        after_idx   = cur_idx;
        item_last   = 1'b1;
        unique case (cur_phase)
            PH_HEAD: begin
                if (cur.has_bits) begin
                    after_phase = PH_BITS;
                    after_idx   = WORD_TOP_IDX;
                    item_last   = 1'b0;
                end else if (cur.has_tail) begin
                    after_phase = PH_GAIN;
                    after_idx   = GAIN_TOP_IDX;
                    item_last   = 1'b0;
                end
            end
            PH_BITS: begin
                if (cur_idx != '0) begin
                    after_phase = PH_BITS;
                    after_idx   = cur_idx - IDX_W'(1);
                    item_last   = 1'b0;
                end else if (cur.has_tail) begin
                    after_phase = PH_GAIN;
                    after_idx   = GAIN_TOP_IDX;
                    item_last   = 1'b0;
                end
            end
            PH_GAIN: begin
                item_last = 1'b0;
                if (cur_idx != '0) begin
                    after_phase = PH_GAIN;
                    after_idx   = cur_idx - IDX_W'(1);
                end else begin
                    after_phase = PH_TRAIL;
                end
            end
            default: begin
                after_phase = PH_IDLE;
            end
        endcase
        if (step) begin
            state_next = item_last ? PH_IDLE : after_phase;
            idx_next   = after_idx;
        end else begin
            state_next = state_reg;
            idx_next   = idx_reg;
        end
    end

    // outputs
    always_comb begin
        bit_val = 1'b0;
        item    = '0;
        unique case (cur_phase)
            PH_HEAD: begin
                item.first_ticks  = RESET_LOW_TICKS;
                item.second_ticks = HEAD_TAIL_TICKS;
            end
            PH_BITS, PH_GAIN: begin
                bit_val = (cur_phase == PH_BITS) ? cur.word[cur_idx]
                                                 : cur.gain[cur_idx[IDX_W-2:0]];
                item.first_level  = 1'b1;
                item.first_ticks  = bit_val ? ONE_HIGH_TICKS : ZERO_HIGH_TICKS;
                item.second_ticks = bit_val ? ONE_LOW_TICKS : ZERO_LOW_TICKS;
            end
            PH_TRAIL: begin
                item.first_ticks    = RESET_LOW_TICKS;
                item.second_ticks   = TRAIL_TAIL_TICKS;
                item.frame_overflow = cur.overflow;
            end
            default: begin
                item = '0;
            end
        endcase
        item.last_of_run = item_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PH_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (adv) begin
                out_valid_reg <= have;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_item_reg <= item;
        end
        if (idle && step) begin
            cmd_reg <= cmd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
